@@ rtl/fixed_huffman_escape_decoder_top_defines.svh @@
// Assertion macros for the fixed prefix-code decoder.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef FIXED_HUFFMAN_ESCAPE_DECODER_TOP_DEFINES_SVH
`define FIXED_HUFFMAN_ESCAPE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication: cond holds -> expr holds.
`define FHED_ASSERT_SAME(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication: cond holds -> expr holds in the next cycle.
`define FHED_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ rtl/fhed_pkg.sv @@
// Shared types, constants and code-tree table of the fixed prefix-code decoder.
// No dependencies.
`timescale 1ns / 1ps

package fhed_pkg;

   localparam int MAX_RESULTS  = 8;
   localparam int REMAIN_W     = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH  = 2;
   localparam int ESC_LAST_BIT = 7;

   localparam logic [1:0] HDR_RESET = 2'd2;
   localparam logic [1:0] HDR_MAX   = 2'd2;

   // Internal nodes of the code tree, named by the path from the root.
   localparam logic [3:0] NODE_ROOT   = 4'd0;
   localparam logic [3:0] NODE_0      = 4'd1;
   localparam logic [3:0] NODE_00     = 4'd2;
   localparam logic [3:0] NODE_000    = 4'd3;
   localparam logic [3:0] NODE_001    = 4'd4;
   localparam logic [3:0] NODE_0000   = 4'd5;
   localparam logic [3:0] NODE_0001   = 4'd6;
   localparam logic [3:0] NODE_00000  = 4'd7;
   localparam logic [3:0] NODE_000000 = 4'd8;

   localparam logic [7:0] SYM_00 = 8'h00;
   localparam logic [7:0] SYM_01 = 8'h01;
   localparam logic [7:0] SYM_02 = 8'h02;
   localparam logic [7:0] SYM_03 = 8'h03;
   localparam logic [7:0] SYM_04 = 8'h04;
   localparam logic [7:0] SYM_FC = 8'hfc;
   localparam logic [7:0] SYM_FD = 8'hfd;
   localparam logic [7:0] SYM_FE = 8'hfe;
   localparam logic [7:0] SYM_FF = 8'hff;

   // One queued item, classified by the front.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       frame_end;
      logic       is_header;
   } fhed_item_type;

   // One step of the code tree: emit a symbol, start an escape, or move on.
   typedef struct packed {
      logic       emit;
      logic       esc;
      logic [7:0] value;
   } fhed_step_type;

   typedef struct packed {
      logic [3:0] node;
      logic       esc_active;
      logic [2:0] esc_cnt;
      logic [7:0] esc_shift;
   } fhed_dec_state_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] syms;
      logic [REMAIN_W-1:0]         count;
      fhed_dec_state_type          state;
   } fhed_decode_type;

   // Back-end status, watched by the top-level checks.
   typedef struct packed {
      logic                load;
      logic                header;
      logic [REMAIN_W-1:0] count;
   } fhed_back_stat_type;

   function automatic fhed_step_type fhed_next(input logic [3:0] node, input logic b);
      fhed_step_type s;
      s = '0;
      case (node)
         NODE_ROOT: begin
            if (b) begin s.emit = 1'b1; s.value = SYM_00; end
            else s.value = {4'd0, NODE_0};
         end
         NODE_0: begin
            if (b) s.esc = 1'b1;
            else s.value = {4'd0, NODE_00};
         end
         NODE_00: s.value = b ? {4'd0, NODE_001} : {4'd0, NODE_000};
         NODE_000: s.value = b ? {4'd0, NODE_0001} : {4'd0, NODE_0000};
         NODE_001: begin
            s.emit  = 1'b1;
            s.value = b ? SYM_FF : SYM_01;
         end
         NODE_0000: begin
            if (b) begin s.emit = 1'b1; s.value = SYM_02; end
            else s.value = {4'd0, NODE_00000};
         end
         NODE_0001: begin
            s.emit  = 1'b1;
            s.value = b ? SYM_FE : SYM_FD;
         end
         NODE_00000: begin
            if (b) begin s.emit = 1'b1; s.value = SYM_03; end
            else s.value = {4'd0, NODE_000000};
         end
         NODE_000000: begin
            s.emit  = 1'b1;
            s.value = b ? SYM_FC : SYM_04;
         end
         default: s.value = {4'd0, NODE_ROOT};
      endcase
      return s;
   endfunction

endpackage

@@ rtl/fhed_req_if.sv @@
// Request channel: one compressed byte per item with valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps

interface fhed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       frame_end;

   modport source (output valid, output in_byte, output frame_end, input ready);
   modport sink (input valid, input in_byte, input frame_end, output ready);
endinterface

@@ rtl/fhed_rsp_if.sv @@
// Response channel: one decoded byte per item with valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps

interface fhed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink (input valid, input out_byte, input last, output ready);
endinterface

@@ rtl/fhed_front.sv @@
// Front end: header byte counting and classification, holds the header register.
// Depends on fhed_pkg and fhed_req_if.
`timescale 1ns / 1ps

module fhed_front
   import fhed_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   fhed_req_if.sink      req_if,
   input  logic          csr_write_en,
   input  logic [1:0]    csr_write_data,
   output logic          push_valid,
   input  logic          push_ready,
   output fhed_item_type push_item
);

   logic [1:0] hdr_cfg_ff, hdr_cfg_in;
   logic [1:0] hdr_seen_ff, hdr_seen_in;
   logic [1:0] hdr_len;
   logic       is_header;
   logic       accept;

   // A register value of three counts as two.
   assign hdr_len   = (hdr_cfg_ff > HDR_MAX) ? HDR_MAX : hdr_cfg_ff;
   assign is_header = hdr_seen_ff < hdr_len;
   assign accept    = req_if.valid && push_ready;

   assign req_if.ready         = push_ready;
   assign push_valid           = req_if.valid;
   assign push_item.in_byte    = req_if.in_byte;
   assign push_item.frame_end  = req_if.frame_end;
   assign push_item.is_header  = is_header;

   always_comb begin
      hdr_cfg_in  = csr_write_en ? csr_write_data : hdr_cfg_ff;
      hdr_seen_in = hdr_seen_ff;
      if (accept) begin
         if (req_if.frame_end) hdr_seen_in = 2'd0;
         else if (is_header)   hdr_seen_in = hdr_seen_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cfg_ff  <= HDR_RESET;
         hdr_seen_ff <= 2'd0;
      end else begin
         hdr_cfg_ff  <= hdr_cfg_in;
         hdr_seen_ff <= hdr_seen_in;
      end
   end

endmodule

@@ rtl/fhed_queue.sv @@
// Small FIFO of classified items between front and back end.
// Depends on fhed_pkg.
`timescale 1ns / 1ps

module fhed_queue
   import fhed_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  fhed_item_type in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output fhed_item_type out_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   fhed_item_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != FULL_CNT;
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_item;
   end

endmodule

@@ rtl/fhed_back.sv @@
// Back end: tree-decodes a byte, buffers results, drains one a cycle while ready.
// Depends on fhed_pkg and fhed_rsp_if.
`timescale 1ns / 1ps

module fhed_back
   import fhed_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_ready,
   input  fhed_item_type      item,
   fhed_rsp_if.source         rsp_if,
   output fhed_back_stat_type stat
);

   fhed_dec_state_type          dec_ff, dec_in;
   logic [MAX_RESULTS-1:0][7:0] buf_ff, buf_in;
   logic [REMAIN_W-1:0]         remain_ff, remain_in;
   fhed_decode_type             dec_res;
   logic                        load, drain;

   // Eight bit steps of the tree (or escape collector) over one byte.
   function automatic fhed_decode_type decode(input fhed_dec_state_type st,
                                              input logic [7:0] din);
      fhed_decode_type r;
      fhed_step_type   s;
      logic            b;
      r       = '0;
      r.state = st;
      for (int i = 0; i < 8; i++) begin
         b = din[3'(7 - i)];
         if (r.state.esc_active) begin
            r.state.esc_shift = {r.state.esc_shift[6:0], b};
            if (r.state.esc_cnt == 3'(ESC_LAST_BIT)) begin
               r.syms[r.count[2:0]] = r.state.esc_shift;
               r.count              = r.count + 1'b1;
               r.state.esc_active   = 1'b0;
               r.state.esc_cnt      = 3'd0;
               r.state.esc_shift    = 8'd0;
            end else begin
               r.state.esc_cnt = r.state.esc_cnt + 3'd1;
            end
         end else begin
            s = fhed_next(r.state.node, b);
            if (s.emit) begin
               r.syms[r.count[2:0]] = s.value;
               r.count              = r.count + 1'b1;
               r.state.node         = NODE_ROOT;
            end else if (s.esc) begin
               r.state.esc_active = 1'b1;
               r.state.esc_cnt    = 3'd0;
               r.state.esc_shift  = 8'd0;
               r.state.node       = NODE_ROOT;
            end else begin
               r.state.node = s.value[3:0];
            end
         end
      end
      return r;
   endfunction

   assign dec_res = decode(dec_ff, item.in_byte);

   // A new byte may load once the buffer is empty or its last result leaves now.
   assign item_ready = (remain_ff == '0) || ((remain_ff == REMAIN_W'(1)) && rsp_if.ready);
   assign load       = item_valid && item_ready;
   assign drain      = rsp_if.valid && rsp_if.ready;

   assign rsp_if.valid    = remain_ff != '0;
   assign rsp_if.out_byte = buf_ff[0];
   assign rsp_if.last     = remain_ff == REMAIN_W'(1);

   assign stat.load   = load;
   assign stat.header = item.is_header;
   assign stat.count  = item.is_header ? REMAIN_W'(1) : dec_res.count;

   always_comb begin
      dec_in    = dec_ff;
      buf_in    = buf_ff;
      remain_in = remain_ff;
      if (load) begin
         if (item.is_header) begin
            buf_in[0] = item.in_byte;
            remain_in = REMAIN_W'(1);
         end else begin
            buf_in    = dec_res.syms;
            remain_in = dec_res.count;
            dec_in    = dec_res.state;
         end
         if (item.frame_end) dec_in = '0;
      end else if (drain) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) buf_in[i] = buf_ff[i + 1];
         remain_in = remain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff    <= '0;
         remain_ff <= '0;
      end else begin
         dec_ff    <= dec_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

@@ rtl/fixed_huffman_escape_decoder_top.sv @@
// Fixed prefix-code decoder with escape literal and raw frame header.
// Usage:
//   req_if  : one compressed byte per item (in_byte, frame_end), valid/ready.
//   rsp_if  : one decoded byte per item (out_byte, last), valid/ready; last
//             marks the final result caused by one input byte.
//   csr_*   : write of raw_header_bytes (0..2, three acts as two); write only
//             while the block is idle.
// Path: an accepted item is registered in the queue, then loaded into the
//   result buffer once that is free; its first result then shows on rsp_if.
// Throughput: a byte giving several results holds the back end until they
//   have left the result buffer, one result per cycle while the receiver is
//   ready; header bytes and bytes with zero or one result go at one per cycle
//   while ready; a byte of eight one-bit codes is paced by the single result port.
// The front counts header bytes and classifies; a small queue (QUEUE_DEPTH
//   items) decouples it from the back, which walks all 8 bits combinationally
//   and drains the buffered results.
// Reset: synchronous, sets raw_header_bytes to 2, the tree to the root and
//   drops queued and buffered items.
// Receiver stall: results hold in the buffer; the queue keeps taking input
//   items until it fills, then req_if.ready drops.
`timescale 1ns / 1ps
`include "fixed_huffman_escape_decoder_top_defines.svh"

module fixed_huffman_escape_decoder_top
   import fhed_pkg::*;
#(
   parameter int QUEUE_DEPTH = fhed_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   fhed_req_if.sink   req_if,
   fhed_rsp_if.source rsp_if,
   input  logic       csr_write_en,
   input  logic [1:0] csr_write_data
);

   // front -> queue
   logic               push_valid;
   logic               push_ready;
   fhed_item_type      push_item;
   // queue -> back
   logic               item_valid;
   logic               item_ready;
   fhed_item_type      item;
   fhed_back_stat_type back_stat;

   fhed_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item)
   );

   fhed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (item_valid),
      .out_ready (item_ready),
      .out_item  (item)
   );

   fhed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_if     (rsp_if),
      .stat       (back_stat)
   );

   // A loaded byte with results must present one next cycle.
   `FHED_ASSERT_NEXT(a_load_shows, back_stat.load && (back_stat.count != '0), rsp_if.valid, "loaded results not shown")
   // A header byte is always a lone result.
   `FHED_ASSERT_NEXT(a_hdr_lone, back_stat.load && back_stat.header, rsp_if.valid && rsp_if.last, "header byte not a single result")
   // Taking a non-final result leaves more results of the same byte.
   `FHED_ASSERT_NEXT(a_more_follow, rsp_if.valid && rsp_if.ready && !rsp_if.last, rsp_if.valid, "results of a byte lost")
   // The back end never loads while a non-final result is pending.
   `FHED_ASSERT_SAME(a_no_overrun, back_stat.load && rsp_if.valid, rsp_if.last && rsp_if.ready, "buffer overrun")

endmodule

@@ dv/tb_fixed_huffman_escape_decoder_top.sv @@
// Self-checking testbench for fixed_huffman_escape_decoder_top.
// Depends on fhed_pkg, fhed_req_if, fhed_rsp_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_fixed_huffman_escape_decoder_top;
   import fhed_pkg::*;

   // Run limits and pacing
   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD   = 150;   // receiver hold-off, long enough to fill the queue
   localparam int SETTLE      = 8;     // idle cycles after the last result
   localparam int PHASE_ITEMS = 45;

   // Escape prefix and the full symbol set, used to build well-formed streams
   localparam logic [1:0] ESC_PREFIX = 2'b01;
   localparam logic [7:0] CODE_SYMS [0:8] = '{SYM_00, SYM_01, SYM_02, SYM_03, SYM_04,
                                              SYM_FC, SYM_FD, SYM_FE, SYM_FF};

   // Predicts the decoded bytes for every accepted input item and checks
   // results in order against them.
   class decode_scoreboard;
      typedef struct packed {
         logic [7:0] out_byte;
         logic       last;
      } decoded_type;

      logic [1:0]  header_len;
      logic [3:0]  node;
      logic        esc_on;
      logic [2:0]  esc_cnt;
      logic [7:0]  esc_shift;
      logic [1:0]  header_seen;
      decoded_type expected_q[$];
      int          mismatches;
      int          results_checked;

      function new();
         header_len      = HDR_RESET;
         mismatches      = 0;
         results_checked = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         node        = NODE_ROOT;
         esc_on      = 1'b0;
         esc_cnt     = 3'd0;
         esc_shift   = 8'd0;
         header_seen = 2'd0;
      endfunction

      function void set_header(logic [1:0] v);
         header_len = v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_byte(logic [7:0] v, logic fend);
         logic [1:0]  hdr_len;
         logic [7:0]  found [0:7];
         int          n;
         logic        bv;
         logic        emit;
         logic [7:0]  sym_v;
         decoded_type item;

         hdr_len = (header_len > HDR_MAX) ? HDR_MAX : header_len;
         n = 0;
         if (header_seen < hdr_len) begin
            item.out_byte = v;
            item.last     = 1'b1;
            expected_q.insert(expected_q.size(), item);
            header_seen = header_seen + 2'd1;
            if (fend) clear_frame();
            return;
         end

         for (int i = 7; i >= 0; i--) begin
            bv = v[i];
            if (esc_on) begin
               esc_shift = {esc_shift[6:0], bv};
               if (esc_cnt == 3'd7) begin
                  found[n] = esc_shift;
                  n++;
                  esc_on    = 1'b0;
                  esc_cnt   = 3'd0;
                  esc_shift = 8'd0;
               end else begin
                  esc_cnt = esc_cnt + 3'd1;
               end
            end else begin
               emit  = 1'b0;
               sym_v = 8'd0;
               case (node)
                  NODE_ROOT: begin
                     if (bv) begin emit = 1'b1; sym_v = SYM_00; end
                     else node = NODE_0;
                  end
                  NODE_0: begin
                     if (bv) begin
                        esc_on    = 1'b1;
                        esc_cnt   = 3'd0;
                        esc_shift = 8'd0;
                        node      = NODE_ROOT;
                     end else begin
                        node = NODE_00;
                     end
                  end
                  NODE_00:  node = bv ? NODE_001 : NODE_000;
                  NODE_000: node = bv ? NODE_0001 : NODE_0000;
                  NODE_001: begin emit = 1'b1; sym_v = bv ? SYM_FF : SYM_01; end
                  NODE_0000: begin
                     if (bv) begin emit = 1'b1; sym_v = SYM_02; end
                     else node = NODE_00000;
                  end
                  NODE_0001: begin emit = 1'b1; sym_v = bv ? SYM_FE : SYM_FD; end
                  NODE_00000: begin
                     if (bv) begin emit = 1'b1; sym_v = SYM_03; end
                     else node = NODE_000000;
                  end
                  NODE_000000: begin emit = 1'b1; sym_v = bv ? SYM_FC : SYM_04; end
                  default: node = NODE_ROOT;
               endcase
               if (emit) begin
                  found[n] = sym_v;
                  n++;
                  node = NODE_ROOT;
               end
            end
         end

         for (int k = 0; k < n; k++) begin
            item.out_byte = found[k];
            item.last     = (k == n - 1);
            expected_q.insert(expected_q.size(), item);
         end
         if (fend) clear_frame();
      endfunction

      function void check_byte(logic [7:0] got_byte, logic got_last);
         decoded_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result: out_byte=%h last=%b", got_byte, got_last);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         results_checked++;
         if (got_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, got_byte);
            mismatches++;
         end
         if (got_last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, got_last);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_en = 1'b0;
   logic [1:0] csr_write_data = 2'd0;

   fhed_req_if req_if ();
   fhed_rsp_if rsp_if ();

   decode_scoreboard sb = new();

   int   cycle_count = 0;
   int   items_sent = 0;
   bit   send_gaps = 1'b1;   // sender idles between items when set
   bit   hold_request = 1'b0; // asks the receiver for one long hold-off
   logic [1:0] header_now = HDR_RESET;

   // Stream under construction: compressed bits, then the bytes of one frame
   logic       stream_bits[$];
   logic [7:0] frame_q[$];

   fixed_huffman_escape_decoder_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // Mostly no gap, some short ones, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void push_bits(logic [7:0] v, int len);
      for (int i = len - 1; i >= 0; i--) stream_bits.insert(stream_bits.size(), v[i]);
   endfunction

   function automatic void append_code(logic [7:0] sym_v);
      case (sym_v)
         SYM_00: push_bits(8'b1, 1);
         SYM_01: push_bits(8'b0010, 4);
         SYM_02: push_bits(8'b00001, 5);
         SYM_03: push_bits(8'b000001, 6);
         SYM_04: push_bits(8'b0000000, 7);
         SYM_FC: push_bits(8'b0000001, 7);
         SYM_FD: push_bits(8'b00010, 5);
         SYM_FE: push_bits(8'b00011, 5);
         SYM_FF: push_bits(8'b0011, 4);
         default: ;
      endcase
   endfunction

   function automatic void append_literal(logic [7:0] v);
      push_bits({6'd0, ESC_PREFIX}, 2);
      push_bits(v, 8);
   endfunction

   // Pads the bit stream to whole bytes and appends them to the frame.
   // pad < 0 fills with random bits, otherwise with the given bit.
   function automatic void pack_stream(int pad);
      logic [7:0] v;
      v = 8'd0;
      while (stream_bits.size() % 8 != 0)
         stream_bits.insert(stream_bits.size(),
                            pad < 0 ? 1'($urandom_range(0, 1)) : 1'(pad));
      while (stream_bits.size() > 0) begin
         for (int i = 0; i < 8; i++) v = {v[6:0], stream_bits.pop_front()};
         frame_q.insert(frame_q.size(), v);
      end
   endfunction

   // Offer one item and hold it until the block takes it. Starts and ends on a
   // falling edge; valid stays high so back-to-back items follow without a gap.
   task automatic send_byte(logic [7:0] v, logic fend);
      req_if.valid     = 1'b1;
      req_if.in_byte   = v;
      req_if.frame_end = fend;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_byte(v, fend);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic pace_sender();
      int g;
      if (send_gaps) begin
         g = pick_gap();
         if (g > 0) begin
            req_if.valid = 1'b0;
            repeat (g) @(negedge clock);
         end
      end
   endtask

   // Sends the queued frame, frame_end on its last byte. Noise frames also
   // cut frames short at random points.
   task automatic send_frame(bit noise);
      logic fend;
      for (int i = 0; i < frame_q.size(); i++) begin
         fend = (i == frame_q.size() - 1) || (noise && $urandom_range(0, 7) == 0);
         send_byte(frame_q[i], fend);
         pace_sender();
      end
      frame_q.delete();
   endtask

   // Sender pause: nothing offered until every predicted result is out, then an
   // idle wait of SETTLE so bytes that make no result also leave the pipeline.
   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_header(logic [1:0] v);
      csr_write_en   = 1'b1;
      csr_write_data = v;
      @(negedge clock);
      csr_write_en = 1'b0;
      sb.set_header(v);
      header_now = v;
   endtask

   // One random frame: mostly well-formed code streams behind a proper header,
   // the rest raw noise and frames shorter than the header.
   task automatic send_random_frame();
      int   r;
      int   n;
      int   hdr;
      bit   ones_only;
      hdr = (header_now > HDR_MAX) ? HDR_MAX : header_now;
      r = $urandom_range(0, 99);
      send_gaps = ($urandom_range(0, 3) != 0);
      if (r < 70) begin
         for (int i = 0; i < hdr; i++)
            frame_q.insert(frame_q.size(), 8'($urandom_range(0, 255)));
         ones_only = ($urandom_range(0, 9) == 0);   // runs of one-bit codes, 8 per byte
         n = ones_only ? $urandom_range(8, 24) : $urandom_range(1, 12);
         for (int i = 0; i < n; i++) begin
            if (ones_only) append_code(SYM_00);
            else if ($urandom_range(0, 4) == 0) append_literal(8'($urandom_range(0, 255)));
            else append_code(CODE_SYMS[$urandom_range(0, 8)]);
         end
         pack_stream(-1);
         send_frame(1'b0);
      end else if (r < 85) begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++)
            frame_q.insert(frame_q.size(), 8'($urandom_range(0, 255)));
         send_frame(1'b1);
      end else begin
         // shorter than the header (or a single byte when there is none)
         n = (hdr == 0) ? 1 : $urandom_range(1, hdr);
         for (int i = 0; i < n; i++)
            frame_q.insert(frame_q.size(), 8'($urandom_range(0, 255)));
         send_frame(1'b0);
      end
   endtask

   task automatic run_random(int count);
      int start;
      start = items_sent;
      while (items_sent - start < count) send_random_frame();
   endtask

   // Timeout guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result monitor: an item moves when valid and ready are both high at the edge.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         sb.check_byte(rsp_if.out_byte, rsp_if.last);
   end

   // Receiver: random stalls, occasional quiet stretches of steady ready, and
   // one long hold-off on request, counted here.
   initial begin
      int g;
      int quiet_left;
      quiet_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (quiet_left > 0) begin
            quiet_left--;
         end else if ($urandom_range(0, 49) == 0) begin
            quiet_left = $urandom_range(20, 60);
         end else begin
            g = pick_gap();
            if (g > 0) begin
               rsp_if.ready = 1'b0;
               repeat (g) @(negedge clock);
            end
         end
         rsp_if.ready = 1'b1;
      end
   end

   // Main sequence
   initial begin
      req_if.valid     = 1'b0;
      req_if.in_byte   = 8'd0;
      req_if.frame_end = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, header length at its reset value of two.
      // Frame: extreme header bytes, every code word, two escapes crossing
      // byte boundaries, then an escape cut off by the frame end (dropped).
      frame_q.insert(frame_q.size(), 8'h00);
      frame_q.insert(frame_q.size(), 8'hff);
      foreach (CODE_SYMS[i]) append_code(CODE_SYMS[i]);
      append_literal(8'ha5);
      append_literal(8'h5a);
      push_bits({6'd0, ESC_PREFIX}, 2);
      push_bits(8'b101, 3);
      pack_stream(1);
      send_frame(1'b0);

      // Short frame: one byte only passes through, the next frame has a new header.
      send_byte(8'h3c, 1'b1);
      // Header, then a byte with no result (escape started), the escape finished
      // in the next byte, and the tree walk continued across bytes.
      frame_q = '{8'h11, 8'h22, 8'h40, 8'h00, 8'h80};
      send_frame(1'b0);

      wait_drained();
      write_header(2'd0);
      // No header: eight one-bit codes from one byte, then a spanning escape.
      frame_q = '{8'hff, 8'h40, 8'h01};
      send_frame(1'b0);

      // Random phases over the header settings
      run_random(PHASE_ITEMS);

      wait_drained();
      write_header(2'd1);
      // Receiver holds off while the sender keeps offering: queue fills up.
      hold_request = 1'b1;
      run_random(PHASE_ITEMS);

      wait_drained();
      write_header(2'd3);   // out of range, acts as two
      run_random(PHASE_ITEMS / 2);
      wait_drained();       // sender pause until everything is out
      run_random(PHASE_ITEMS / 2);

      wait_drained();
      write_header(2'd2);
      run_random(PHASE_ITEMS);

      wait_drained();
      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
         sb.mismatches++;
      end

      $display("tb: %0d compressed items sent, %0d decoded results checked",
               items_sent, sb.results_checked);
      $display("tb: header lengths 2, 0, 1, 3 and 2 exercised, with stalls on both sides");
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
